// File: src/dpc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dpc_pkg
// Shared types, constants and helpers for the drivable pixel classifier:
// frame limits, field widths, register indexes and the luminance weights.
// ----------------------------------------------------------------------------
package dpc_pkg;

    // Frame size limits
    localparam int MAX_FRAME_WIDTH  = 4096;
    localparam int MAX_FRAME_HEIGHT = 4096;

    // Widths of positions, register fields and counts
    localparam int COL_W      = $clog2(MAX_FRAME_WIDTH);
    localparam int ROW_W      = $clog2(MAX_FRAME_HEIGHT);
    localparam int DIM_W      = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int PIXEL_W    = 16;
    localparam int COUNT_W    = 25;
    localparam int TRIPLE_W   = ROW_W + 2;
    localparam int QUINT_W    = ROW_W + 3;
    localparam int LUM_W      = 24;
    localparam int CHAN_W     = 8;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_MODE   = 2'd2;

    // Reset values of the registers
    localparam logic [DIM_W-1:0] RESET_FRAME_WIDTH  = 13'd320;
    localparam logic [DIM_W-1:0] RESET_FRAME_HEIGHT = 13'd240;
    localparam logic             RESET_COLOR_MODE   = 1'b1;

    // Colour rule constants: Q8.16 luminance weights summing to 65536
    localparam logic [LUM_W-1:0]  LUM_WR       = 24'd19595;
    localparam logic [LUM_W-1:0]  LUM_WG       = 24'd38470;
    localparam logic [LUM_W-1:0]  LUM_WB       = 24'd7471;
    localparam logic [LUM_W-1:0]  BRIGHT_LIMIT = 24'd8388608;
    localparam logic [CHAN_W-1:0] GRAY_LIMIT   = 8'd50;

    // Row geometry derived from the frame height
    typedef struct packed {
        logic [ROW_W-1:0]    row_last;  // clamped height minus one
        logic [ROW_W-1:0]    row_half;  // floor(height / 2)
        logic [TRIPLE_W-1:0] triple;    // 3 * height
    } geom_t;

    // Clamp a dimension to 1..max and return it minus one
    function automatic logic [COL_W-1:0] dim_last(input logic [DIM_W-1:0] v,
                                                 input int maxv);
        logic [DIM_W:0] v_ext;
        logic [DIM_W:0] max_ext;
        logic [DIM_W:0] res;
        v_ext   = {1'b0, v};
        max_ext = (DIM_W+1)'(maxv);
        if (v_ext == '0)
            res = '0;
        else if (v_ext > max_ext)
            res = max_ext - 1'b1;
        else
            res = v_ext - 1'b1;
        return res[COL_W-1:0];
    endfunction

    // Build the row geometry from a raw height register value
    function automatic geom_t make_geom(input logic [DIM_W-1:0] h_raw);
        geom_t            g;
        logic [COL_W-1:0] h_dim;
        logic [ROW_W:0]   h_full;
        logic [ROW_W-1:0] h_last;
        logic [ROW_W:0]   h_half;
        h_dim      = dim_last(h_raw, MAX_FRAME_HEIGHT);
        h_last     = h_dim[ROW_W-1:0];
        h_full     = {1'b0, h_last} + 1'b1;
        h_half     = h_full >> 1;
        g.row_last = h_last;
        g.row_half = h_half[ROW_W-1:0];
        g.triple   = TRIPLE_W'({h_full, 1'b0}) + TRIPLE_W'(h_full);
        return g;
    endfunction

endpackage
`default_nettype wire

// File: src/dpc_classify.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dpc_classify
// Per-pixel drivable decision: colour rule (bright and gray, or lower half)
// for RGB565 input, position rule (5*row > 3*height) otherwise.
// ----------------------------------------------------------------------------
module dpc_classify (
    input  wire logic [dpc_pkg::PIXEL_W-1:0] pixel_word,
    input  wire logic [dpc_pkg::ROW_W-1:0]   row,
    input  wire dpc_pkg::geom_t              geom,
    input  wire logic                        color_mode,
    output logic                             drivable
);
    import dpc_pkg::*;

    logic [CHAN_W-1:0]  r8;
    logic [CHAN_W-1:0]  g8;
    logic [CHAN_W-1:0]  b8;
    logic [LUM_W-1:0]   lum;
    logic [CHAN_W-1:0]  d_rg;
    logic [CHAN_W-1:0]  d_rb;
    logic [CHAN_W-1:0]  d_gb;
    logic [CHAN_W-1:0]  d_max;
    logic               bright;
    logic               gray;
    logic               lower;
    logic [QUINT_W-1:0] row5;
    logic               pos_rule;

    // Expand RGB565 to 8-bit channels
    assign r8 = {pixel_word[15:11], 3'b000};
    assign g8 = {pixel_word[10:5], 2'b00};
    assign b8 = {pixel_word[4:0], 3'b000};

    // Weighted luminance in Q8.16
    assign lum = LUM_WR * LUM_W'(r8) + LUM_WG * LUM_W'(g8) + LUM_WB * LUM_W'(b8);
    assign bright = lum > BRIGHT_LIMIT;

    // Largest channel difference
    always_comb
    begin
        d_rg  = (r8 > g8) ? r8 - g8 : g8 - r8;
        d_rb  = (r8 > b8) ? r8 - b8 : b8 - r8;
        d_gb  = (g8 > b8) ? g8 - b8 : b8 - g8;
        d_max = d_rg;
        if (d_rb > d_max)
            d_max = d_rb;
        if (d_gb > d_max)
            d_max = d_gb;
    end

    assign gray  = d_max < GRAY_LIMIT;
    assign lower = row > geom.row_half;

    // Position-only rule
    assign row5     = QUINT_W'({row, 2'b00}) + QUINT_W'(row);
    assign pos_rule = row5 > QUINT_W'(geom.triple);

    assign drivable = color_mode ? ((bright && gray) || lower) : pos_rule;

endmodule
`default_nettype wire

// File: src/drivable_pixel_classifier.sv
`default_nettype none
// ----------------------------------------------------------------------------
// drivable_pixel_classifier
// Classifies a raster pixel stream into drivable and non-drivable area,
// tracks column and row, and reports both class totals on the last pixel.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+---------------------------------
//  pixel    | in        | pixel_valid / pixel_ready  | pixel_word, frame_start
//  result   | out       | result_valid / result_ready| mask_class, frame_last, totals
//  cfg      | in        | cfg_write                  | cfg_index, cfg_data
//
//  After a pixel is accepted it lands in the input register; the
//  classification and counter update then load the result register when
//  the output stage advances, and result_valid rises.
//  One pixel per cycle sustained; both stages advance together when the
//  result register is empty or being drained.
//  Reset clears position, counts and valid flags and loads 320x240, colour.
//  A stalled result holds the input stage; pixel_ready drops only then.
// ----------------------------------------------------------------------------
module drivable_pixel_classifier (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             pixel_valid,
    output logic                                  pixel_ready,
    input  wire logic [dpc_pkg::PIXEL_W-1:0]      pixel_word,
    input  wire logic                             frame_start,
    output logic                                  result_valid,
    input  wire logic                             result_ready,
    output logic                                  mask_class,
    output logic                                  frame_last,
    output logic [dpc_pkg::COUNT_W-1:0]           drivable_total,
    output logic [dpc_pkg::COUNT_W-1:0]           blocked_total,
    input  wire logic                             cfg_write,
    input  wire logic [dpc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [dpc_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import dpc_pkg::*;

    // Configuration, stored in derived form
    logic [COL_W-1:0]   col_last_reg;
    geom_t              geom_reg;
    logic               color_mode_reg;

    // Input stage
    logic               in_valid_reg;
    logic [PIXEL_W-1:0] in_word_reg;
    logic               in_start_reg;

    // Frame state
    logic [COL_W-1:0]   column_reg;
    logic [COL_W-1:0]   column_next;
    logic [ROW_W-1:0]   row_reg;
    logic [ROW_W-1:0]   row_next;
    logic [COUNT_W-1:0] drv_count_reg;
    logic [COUNT_W-1:0] drv_count_next;
    logic [COUNT_W-1:0] blk_count_reg;
    logic [COUNT_W-1:0] blk_count_next;

    // Result stage
    logic               out_valid_reg;
    logic               mask_reg;
    logic               mask_next;
    logic               last_reg;
    logic               last_next;
    logic [COUNT_W-1:0] drv_total_reg;
    logic [COUNT_W-1:0] drv_total_next;
    logic [COUNT_W-1:0] blk_total_reg;
    logic [COUNT_W-1:0] blk_total_next;

    logic               advance;
    logic               fire;
    logic [COL_W-1:0]   col_cur;
    logic [ROW_W-1:0]   row_cur;
    logic [COUNT_W-1:0] drv_base;
    logic [COUNT_W-1:0] blk_base;
    logic [COUNT_W-1:0] drv_new;
    logic [COUNT_W-1:0] blk_new;
    logic               drivable;
    logic               row_end;

    // Handshake
    assign advance     = !out_valid_reg || result_ready;
    assign pixel_ready = !in_valid_reg || advance;
    assign fire        = in_valid_reg && advance;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_last_reg   <= dim_last(RESET_FRAME_WIDTH, MAX_FRAME_WIDTH);
            geom_reg       <= make_geom(RESET_FRAME_HEIGHT);
            color_mode_reg <= RESET_COLOR_MODE;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  col_last_reg   <= dim_last(cfg_data, MAX_FRAME_WIDTH);
                REG_FRAME_HEIGHT: geom_reg       <= make_geom(cfg_data);
                REG_COLOR_MODE:   color_mode_reg <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // Capture accepted transactions
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (pixel_ready)
            in_valid_reg <= pixel_valid;
    end

    always_ff @(posedge clk)
    begin
        if (pixel_valid && pixel_ready)
        begin
            in_word_reg  <= pixel_word;
            in_start_reg <= frame_start;
        end
    end

    dpc_classify u_classify (
        .pixel_word (in_word_reg),
        .row        (row_cur),
        .geom       (geom_reg),
        .color_mode (color_mode_reg),
        .drivable   (drivable)
    );

    // Position, counts and result of the pixel in the input stage
    always_comb
    begin
        col_cur  = in_start_reg ? '0 : column_reg;
        row_cur  = in_start_reg ? '0 : row_reg;
        drv_base = in_start_reg ? '0 : drv_count_reg;
        blk_base = in_start_reg ? '0 : blk_count_reg;

        drv_new = drv_base;
        blk_new = blk_base;
        if (drivable)
        begin
            if (drv_base != COUNT_MAX)
                drv_new = drv_base + 1'b1;
        end
        else
        begin
            if (blk_base != COUNT_MAX)
                blk_new = blk_base + 1'b1;
        end

        row_end   = col_cur >= col_last_reg;
        last_next = row_end && (row_cur >= geom_reg.row_last);
        mask_next = !drivable;
        drv_total_next = last_next ? drv_new : '0;
        blk_total_next = last_next ? blk_new : '0;

        if (last_next)
        begin
            column_next    = '0;
            row_next       = '0;
            drv_count_next = '0;
            blk_count_next = '0;
        end
        else if (row_end)
        begin
            column_next    = '0;
            row_next       = row_cur + 1'b1;
            drv_count_next = drv_new;
            blk_count_next = blk_new;
        end
        else
        begin
            column_next    = col_cur + 1'b1;
            row_next       = row_cur;
            drv_count_next = drv_new;
            blk_count_next = blk_new;
        end
    end

    // Advance frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg    <= '0;
            row_reg       <= '0;
            drv_count_reg <= '0;
            blk_count_reg <= '0;
        end
        else if (fire)
        begin
            column_reg    <= column_next;
            row_reg       <= row_next;
            drv_count_reg <= drv_count_next;
            blk_count_reg <= blk_count_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            mask_reg      <= mask_next;
            last_reg      <= last_next;
            drv_total_reg <= drv_total_next;
            blk_total_reg <= blk_total_next;
        end
    end

    assign result_valid   = out_valid_reg;
    assign mask_class     = mask_reg;
    assign frame_last     = last_reg;
    assign drivable_total = drv_total_reg;
    assign blocked_total  = blk_total_reg;

    // Checks
    a_totals_zero_mid_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !frame_last) |-> (drivable_total == '0 && blocked_total == '0))
        else $error("totals not zero outside frame end");

    a_totals_nonzero_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && frame_last) |-> (drivable_total != '0 || blocked_total != '0))
        else $error("frame end with both totals zero");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> pixel_ready)
        else $error("input stalled while result register empty");

    a_state_cleared_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && last_next) |=> (column_reg == '0 && row_reg == '0
                                 && drv_count_reg == '0 && blk_count_reg == '0))
        else $error("frame state not cleared after last pixel");

endmodule
`default_nettype wire

// File: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench for drivable_pixel_classifier
// Streams pixels through the classifier under several frame geometries and
// both classification rules, with random gaps on the input and random stalls
// on the output. A scoreboard class tracks the raster position and the class
// counts, predicts every result transaction and compares it field by field.
// ----------------------------------------------------------------------------

typedef struct packed {
    logic                         mask_class;
    logic                         frame_last;
    logic [dpc_pkg::COUNT_W-1:0]  drivable_total;
    logic [dpc_pkg::COUNT_W-1:0]  blocked_total;
} pixel_result_t;

class pixel_scoreboard;
    int unsigned   width_reg;
    int unsigned   height_reg;
    bit            colour_rule;
    int unsigned   column;
    int unsigned   row;
    int unsigned   drivable_cnt;
    int unsigned   blocked_cnt;
    pixel_result_t pending[$];
    int unsigned   error_count;
    int unsigned   result_count;
    int unsigned   frame_count;

    function new();
        width_reg    = dpc_pkg::RESET_FRAME_WIDTH;
        height_reg   = dpc_pkg::RESET_FRAME_HEIGHT;
        colour_rule  = dpc_pkg::RESET_COLOR_MODE;
        column       = 0;
        row          = 0;
        drivable_cnt = 0;
        blocked_cnt  = 0;
        error_count  = 0;
        result_count = 0;
        frame_count  = 0;
    endfunction

    // Mirror a register write; writes never touch position or counts
    function void write_reg(logic [dpc_pkg::CFG_IDX_W-1:0] index,
                            logic [dpc_pkg::CFG_DATA_W-1:0] data);
        case (index)
            dpc_pkg::REG_FRAME_WIDTH:  width_reg   = data;
            dpc_pkg::REG_FRAME_HEIGHT: height_reg  = data;
            dpc_pkg::REG_COLOR_MODE:   colour_rule = data[0];
            default: ;
        endcase
    endfunction

    // Zero counts as one, oversize saturates to the frame limit
    function int unsigned clamp_dim(int unsigned v, int unsigned limit);
        if (v == 0)
            return 1;
        if (v > limit)
            return limit;
        return v;
    endfunction

    function int unsigned spread(int unsigned a, int unsigned b);
        return (a > b) ? a - b : b - a;
    endfunction

    // Colour rule or position rule for the current row
    function bit pixel_clear(logic [dpc_pkg::PIXEL_W-1:0] word, int unsigned h);
        int unsigned r8;
        int unsigned g8;
        int unsigned b8;
        int unsigned luma;
        int unsigned widest;
        bit          bright;
        bit          gray;
        if (!colour_rule)
            return 5 * row > 3 * h;
        r8     = {word[15:11], 3'b000};
        g8     = {word[10:5], 2'b00};
        b8     = {word[4:0], 3'b000};
        luma   = int'(dpc_pkg::LUM_WR) * r8 + int'(dpc_pkg::LUM_WG) * g8
               + int'(dpc_pkg::LUM_WB) * b8;
        bright = luma > int'(dpc_pkg::BRIGHT_LIMIT);
        widest = spread(r8, g8);
        if (spread(r8, b8) > widest)
            widest = spread(r8, b8);
        if (spread(g8, b8) > widest)
            widest = spread(g8, b8);
        gray   = widest < int'(dpc_pkg::GRAY_LIMIT);
        return (bright && gray) || (row > h / 2);
    endfunction

    // Predict the result of one accepted pixel and advance the position
    function void note_pixel(logic [dpc_pkg::PIXEL_W-1:0] word, logic start);
        int unsigned   w;
        int unsigned   h;
        bit            drivable;
        bit            row_end;
        bit            last;
        pixel_result_t res;
        w = clamp_dim(width_reg, dpc_pkg::MAX_FRAME_WIDTH);
        h = clamp_dim(height_reg, dpc_pkg::MAX_FRAME_HEIGHT);
        if (start)
        begin
            column       = 0;
            row          = 0;
            drivable_cnt = 0;
            blocked_cnt  = 0;
        end
        drivable = pixel_clear(word, h);
        if (drivable)
            drivable_cnt = (drivable_cnt >= dpc_pkg::COUNT_MAX) ? drivable_cnt
                                                                 : drivable_cnt + 1;
        else
            blocked_cnt = (blocked_cnt >= dpc_pkg::COUNT_MAX) ? blocked_cnt
                                                               : blocked_cnt + 1;
        row_end = column >= w - 1;
        last    = row_end && row >= h - 1;
        res.mask_class     = !drivable;
        res.frame_last     = last;
        res.drivable_total = last ? drivable_cnt[dpc_pkg::COUNT_W-1:0] : '0;
        res.blocked_total  = last ? blocked_cnt[dpc_pkg::COUNT_W-1:0] : '0;
        pending.push_back(res);
        if (last)
        begin
            column       = 0;
            row          = 0;
            drivable_cnt = 0;
            blocked_cnt  = 0;
        end
        else if (row_end)
        begin
            column = 0;
            row    = row + 1;
        end
        else
            column = column + 1;
    endfunction

    // Compare one result transaction with the oldest prediction
    function void check_result(pixel_result_t got);
        pixel_result_t exp;
        result_count++;
        if (pending.size() == 0)
        begin
            $error("result transaction with no pixel outstanding");
            error_count++;
            return;
        end
        exp = pending.pop_front();
        if (exp.frame_last)
            frame_count++;
        if (got.mask_class !== exp.mask_class)
        begin
            $error("mask_class: expected %0d, got %0d", exp.mask_class, got.mask_class);
            error_count++;
        end
        if (got.frame_last !== exp.frame_last)
        begin
            $error("frame_last: expected %0d, got %0d", exp.frame_last, got.frame_last);
            error_count++;
        end
        if (got.drivable_total !== exp.drivable_total)
        begin
            $error("drivable_total: expected %0d, got %0d",
                   exp.drivable_total, got.drivable_total);
            error_count++;
        end
        if (got.blocked_total !== exp.blocked_total)
        begin
            $error("blocked_total: expected %0d, got %0d",
                   exp.blocked_total, got.blocked_total);
            error_count++;
        end
    endfunction
endclass

module testbench;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              pixel_valid = 1'b0;
    logic                              pixel_ready;
    logic [dpc_pkg::PIXEL_W-1:0]       pixel_word = '0;
    logic                              frame_start = 1'b0;
    logic                              result_valid;
    logic                              result_ready = 1'b0;
    logic                              mask_class;
    logic                              frame_last;
    logic [dpc_pkg::COUNT_W-1:0]       drivable_total;
    logic [dpc_pkg::COUNT_W-1:0]       blocked_total;
    logic                              cfg_write = 1'b0;
    logic [dpc_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
    logic [dpc_pkg::CFG_DATA_W-1:0]    cfg_data = '0;

    pixel_scoreboard board = new();
    int unsigned     gap_pct = 0;
    int unsigned     stall_pct = 0;
    int unsigned     hold_left = 0;
    int unsigned     pixels_sent = 0;

    drivable_pixel_classifier DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .pixel_valid    (pixel_valid),
        .pixel_ready    (pixel_ready),
        .pixel_word     (pixel_word),
        .frame_start    (frame_start),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .mask_class     (mask_class),
        .frame_last     (frame_last),
        .drivable_total (drivable_total),
        .blocked_total  (blocked_total),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #2000000;
        $display("testbench: done, errors");
        $finish;
    end

    // Drive result_ready: a long hold-off when asked, otherwise random stalls
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                result_ready <= 1'b0;
                hold_left = hold_left - 1;
            end
            else
                result_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Check every result transaction
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            board.check_result({mask_class, frame_last, drivable_total, blocked_total});
    end

    // Offer one pixel, idling at random first, and note it once accepted
    task automatic send_pixel(input logic [dpc_pkg::PIXEL_W-1:0] word, input logic start);
        @(negedge clk);
        while ($urandom_range(99) < gap_pct)
        begin
            pixel_valid <= 1'b0;
            @(negedge clk);
        end
        pixel_valid <= 1'b1;
        pixel_word  <= word;
        frame_start <= start;
        @(posedge clk);
        while (!pixel_ready)
            @(posedge clk);
        board.note_pixel(word, start);
        pixels_sent++;
    endtask

    task automatic stop_sending();
        @(negedge clk);
        pixel_valid <= 1'b0;
    endtask

    task automatic write_reg(input logic [dpc_pkg::CFG_IDX_W-1:0] index,
                             input int unsigned value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value[dpc_pkg::CFG_DATA_W-1:0];
        board.write_reg(index, value[dpc_pkg::CFG_DATA_W-1:0]);
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // Drain all outstanding results, then let the pipeline settle
    task automatic wait_drained();
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Mix of random words, pure colours and near-gray shades around the limit
    function automatic logic [dpc_pkg::PIXEL_W-1:0] pick_word();
        int          red;
        int          green;
        int          blue;
        logic [15:0] shade;
        case ($urandom_range(9))
            0, 1, 2, 3: return 16'($urandom);
            4:
            begin
                case ($urandom_range(4))
                    0: shade = 16'h0000;
                    1: shade = 16'hFFFF;
                    2: shade = 16'hF800;
                    3: shade = 16'h07E0;
                    default: shade = 16'h001F;
                endcase
                return shade;
            end
            default:
            begin
                red   = $urandom_range(31);
                green = 2 * red + int'($urandom_range(14)) - 7;
                blue  = red + int'($urandom_range(14)) - 7;
                green = (green < 0) ? 0 : (green > 63) ? 63 : green;
                blue  = (blue < 0) ? 0 : (blue > 31) ? 31 : blue;
                return {red[4:0], green[5:0], blue[4:0]};
            end
        endcase
    endfunction

    initial
    begin : stimulus
        logic [15:0] opener[4]  = '{16'h0000, 16'hFFFF, 16'h8410, 16'h8430};
        logic [15:0] small4[16] = '{16'hFFFF, 16'h0000, 16'hF800, 16'h07E0,
                                    16'h001F, 16'h8410, 16'h8430, 16'h0180,
                                    16'h01A0, 16'hFFE0, 16'hC618, 16'h4208,
                                    16'hF800, 16'h001F, 16'h0000, 16'h07E0};
        int unsigned phase_w[12]  = '{5, 1, 0, 7, 8191, 3, 4, 4096, 12, 2, 6, 16};
        int unsigned phase_h[12]  = '{4, 1, 0, 6, 8191, 8191, 2, 3, 10, 5000, 9, 16};
        int unsigned phase_m[12]  = '{1, 1, 0, 0, 1, 0, 1, 0, 1, 1, 0, 1};
        int unsigned phase_n[12]  = '{200, 60, 60, 200, 150, 150, 150, 100, 300, 100,
                                      300, 200};
        bit          phase_fr[12] = '{1, 1, 0, 1, 1, 0, 0, 1, 1, 1, 1, 1};
        int unsigned gap_set[4]   = '{0, 69, 0, 37};
        int unsigned stall_set[4] = '{0, 0, 69, 37};

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset geometry: a few pixels including the exact brightness limit
        foreach (opener[i])
            send_pixel(opener[i], i == 0);
        stop_sending();
        wait_drained();

        // Tiny colour frame: pure colours, gray limits, lower half row
        write_reg(dpc_pkg::REG_FRAME_WIDTH, 4);
        write_reg(dpc_pkg::REG_FRAME_HEIGHT, 4);
        write_reg(dpc_pkg::REG_COLOR_MODE, 1);
        foreach (small4[i])
            send_pixel(small4[i], i == 0);
        stop_sending();
        wait_drained();

        // Random phases; some carry the position over a geometry change
        for (int p = 0; p < 12; p++)
        begin
            gap_pct   = gap_set[p % 4];
            stall_pct = stall_set[p % 4];
            write_reg(dpc_pkg::REG_FRAME_WIDTH, phase_w[p]);
            write_reg(dpc_pkg::REG_FRAME_HEIGHT, phase_h[p]);
            write_reg(dpc_pkg::REG_COLOR_MODE, phase_m[p]);
            // Hold the output off for a long stretch so the input backs up
            if (p == 3 || p == 8)
                hold_left = 200;
            for (int k = 0; k < phase_n[p]; k++)
                send_pixel(pick_word(),
                           (k == 0 && phase_fr[p]) || ($urandom_range(99) < 2));
            stop_sending();
            wait_drained();
        end

        gap_pct   = 0;
        stall_pct = 0;
        repeat (8) @(posedge clk);
        $display("summary: %0d pixels sent, %0d results checked, %0d frame ends seen",
                 pixels_sent, board.result_count, board.frame_count);
        $display("summary: colour and position rules over 14 geometries, %0d mismatches",
                 board.error_count);
        if (board.error_count == 0 && board.pending.size() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
